>>> rtl/mrcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcf_pkg
// shared types, constants and the crc-16/modbus byte fold for the framer
// ----------------------------------------------------------------------------
package mrcf_pkg;

  localparam int unsigned CRC_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_RES = 3;  // most words one input byte can cause
  localparam int unsigned CNT_W   = 2;  // holds 0 .. NUM_RES

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  localparam logic [1:0] SEEN_MAX = 2'd3;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              is_status;
    logic              crc_ok;
  } res_t;

  // words handed from the crc core to the result queue in one cycle
  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   count;
    res_t [NUM_RES-1:0] res;
  } push_t;

  // reflected crc, lsb first, eight bit steps
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mrcf_crc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcf_crc_core
// input register, running crc state and generation of the result words
// ----------------------------------------------------------------------------
module mrcf_crc_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_mode,
  input  logic [mrcf_pkg::BYTE_W-1:0]      in_byte,
  input  logic                             in_last,
  input  logic [mrcf_pkg::CNT_W-1:0]       room,
  output mrcf_pkg::push_t                  push
);

  logic                           s1_valid_r;
  logic                           s1_mode_r;
  logic [mrcf_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                           s1_last_r;
  logic [mrcf_pkg::CRC_W-1:0]     crc_r;
  logic [mrcf_pkg::CRC_W-1:0]     crc_nxt;
  logic [1:0]                     seen_r;
  logic [1:0]                     seen_nxt;
  logic [mrcf_pkg::CRC_W-1:0]     crc_fold;
  logic [1:0]                     seen_inc;
  logic [mrcf_pkg::CNT_W-1:0]     n_res;
  mrcf_pkg::res_t [mrcf_pkg::NUM_RES-1:0] res;
  logic                           push_go;

  always_comb begin
    crc_fold = mrcf_pkg::fold_byte(crc_r, s1_byte_r);
    seen_inc = (seen_r == mrcf_pkg::SEEN_MAX) ? seen_r : seen_r + 2'd1;
    res      = '0;
    n_res    = '0;
    if (s1_mode_r == mrcf_pkg::MODE_GEN) begin
      res[0].out_byte = s1_byte_r;
      n_res           = 2'd1;
      if (s1_last_r) begin
        // crc low byte then high byte, high byte closes the frame
        res[1].out_byte  = crc_fold[7:0];
        res[2].out_byte  = crc_fold[15:8];
        res[2].frame_end = 1'b1;
        n_res            = 2'd3;
      end
    end else if (s1_last_r) begin
      res[0].frame_end = 1'b1;
      res[0].is_status = 1'b1;
      res[0].crc_ok    = (crc_fold == '0) && (seen_inc == mrcf_pkg::SEEN_MAX);
      n_res            = 2'd1;
    end
  end

  assign push_go   = s1_valid_r && (n_res <= room);
  assign in_tready = !s1_valid_r || push_go;

  assign push.valid = push_go;
  assign push.count = n_res;
  assign push.res   = res;

  assign crc_nxt  = s1_last_r ? mrcf_pkg::CRC_INIT : crc_fold;
  assign seen_nxt = s1_last_r ? 2'd0 : seen_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      crc_r      <= mrcf_pkg::CRC_INIT;
      seen_r     <= 2'd0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (push_go) begin
        crc_r  <= crc_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

endmodule

>>> rtl/mrcf_res_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcf_res_queue
// three-entry result queue, takes up to three words a cycle, gives one while out_tready is high
// ----------------------------------------------------------------------------
module mrcf_res_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mrcf_pkg::push_t              push,
  output logic [mrcf_pkg::CNT_W-1:0]   room,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output mrcf_pkg::res_t               head
);

  mrcf_pkg::res_t [mrcf_pkg::NUM_RES-1:0] q_r;
  mrcf_pkg::res_t [mrcf_pkg::NUM_RES-1:0] q_nxt;
  logic [mrcf_pkg::CNT_W-1:0]             cnt_r;
  logic [mrcf_pkg::CNT_W-1:0]             cnt_nxt;
  logic [mrcf_pkg::CNT_W-1:0]             cnt_pop;
  logic [mrcf_pkg::CNT_W-1:0]             k;
  logic                                   pop;

  assign out_tvalid = (cnt_r != '0);
  assign head       = q_r[0];
  assign pop        = out_tvalid && out_tready;
  assign cnt_pop    = cnt_r - {{(mrcf_pkg::CNT_W-1){1'b0}}, pop};
  assign room       = mrcf_pkg::CNT_W'(mrcf_pkg::NUM_RES) - cnt_pop;
  assign cnt_nxt    = push.valid ? cnt_pop + push.count : cnt_pop;

  always_comb begin
    q_nxt = q_r;
    k     = '0;
    for (int i = 0; i < mrcf_pkg::NUM_RES; i++) begin
      if (mrcf_pkg::CNT_W'(i) < cnt_pop) begin
        // surviving entries slide toward the head
        if (pop && (i < mrcf_pkg::NUM_RES - 1)) begin
          q_nxt[i] = q_r[i+1];
        end
      end else begin
        k = mrcf_pkg::CNT_W'(i) - cnt_pop;
        if (push.valid && (k < push.count)) begin
          q_nxt[i] = push.res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

>>> rtl/modbus_rtu_crc_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_crc_framer_top
// crc-16/modbus frame builder and checker on a byte stream
// ----------------------------------------------------------------------------
// Bytes of a modbus rtu frame enter one word per cycle; in_tuser selects the
// mode and in_tlast marks the last byte. Every byte is folded into a
// reflected crc-16 (poly 0xa001, start 0xffff). In build mode (in_tuser 0)
// each byte is echoed, and after the last byte the crc low byte and then the
// high byte are appended, the high byte with out_tlast set. In check mode
// (in_tuser 1) the frame carries its own crc; nothing comes out until the
// last byte, then one status word (out_tuser 1, out_tlast 1) whose crc_ok
// bit is set when the residue is zero and the frame was at least three bytes
// long. The crc resets after every last byte. An input byte is taken every
// cycle as long as the result side keeps up: bytes pass the input register
// and then the result queue, echoed bytes flow at one per cycle, and a
// build-mode last byte produces three words, so the output port sets the
// pace at one word per cycle. The three-entry result queue lets the input
// side keep accepting while results wait on out_tready, as long as the
// queue has room for every word the held byte produces; a build-mode last
// byte needs all three entries free, so it waits until the queue is empty
// or its one remaining word leaves in the same cycle. Check-mode bytes that
// are not last produce nothing and are never held up.
// ----------------------------------------------------------------------------
module modbus_rtu_crc_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode: 0 build, 1 check
  input  logic        in_tlast,   // last byte of the frame
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] crc_ok, [15:9] zero
  output logic        out_tuser,  // [0] is_status
  output logic        out_tlast   // frame_end
);

  mrcf_pkg::push_t                 push;
  logic [mrcf_pkg::CNT_W-1:0]      room;
  mrcf_pkg::res_t                  head;

  // input register, crc state and word generation
  mrcf_crc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .room      (room),
    .push      (push)
  );

  // result queue decouples the output handshake from the crc path
  mrcf_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {7'd0, head.crc_ok, head.out_byte};
  assign out_tuser = head.is_status;
  assign out_tlast = head.frame_end;

endmodule
